@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the RTL of the SCC source and sink counter.
// Depends on the signals clk and arst_n existing in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SCC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define SCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/scc_pkg.sv @@
// Package of the SCC source and sink counter: sizes, codes and sequencer states.
// Has no dependencies; used by scc_source_sink_counter.
package scc_pkg;

	localparam int MAX_NODES_DEF = 1024;
	localparam int MAX_EDGES_DEF = 4096;

	localparam logic MODE_EDGE = 1'b0;
	localparam logic MODE_RUN  = 1'b1;

	localparam logic REG_NUM_NODES = 1'b0;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CLR,
		S_CNT_RD,
		S_CNT_E,
		S_CNT_O,
		S_PRE_RD,
		S_PRE_WR,
		S_FILL_RD,
		S_FILL_E,
		S_FILL_W,
		S_D1_RD,
		S_D1_CHK,
		S_CLRV,
		S_D2_RD,
		S_D2_FIN,
		S_D2_CHK,
		S_W_TOP,
		S_W_ADJ,
		S_W_VIS,
		S_W_OFF,
		S_W_POP,
		S_W_END,
		S_X_RD,
		S_X_E,
		S_X_L,
		S_SC_RD,
		S_SC_ACC,
		S_DONE
	} state_t;

endpackage

@@ hw/rtl/scc_source_sink_counter.sv @@
// Top level of the SCC source and sink counter: edge store, adjacency build,
// two depth-first walks and the cross-edge count under one sequencer.
// Depends on scc_pkg and assert_macros.svh.
//
// Usage: an item transfer with mode 0 stores one directed edge (one-based
// from_node and to_node); item_stall stays low in idle.
// An item with mode 1 runs the analysis; item_stall is high until it ends.
// Every step of the analysis reads or writes RAMs with registered read data.
// A count pass, a prefix pass and a fill pass build both adjacency lists, then
// the forward walk, the reverse walk and the cross-edge pass follow.
// The result is held in an output register; if the receiver stalls, the next
// analysis waits for it at its end, while edge loading goes on as normal.
// Only mode 1 items yield a result transfer. The analysis empties the edge
// store and clears both error flags after reporting them.
// Reset clears the sequencer, the edge count, the flags and the result valid;
// num_nodes resets to 1. No clearing pass is needed: the analysis clears the
// node arrays it uses in its first pass.
// num_nodes is written through the APB port at byte address 0.
`include "assert_macros.svh"

module scc_source_sink_counter #(
	parameter int MAX_NODES = scc_pkg::MAX_NODES_DEF,
	parameter int MAX_EDGES = scc_pkg::MAX_EDGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        mode,
	input  logic [10:0] from_node,
	input  logic [10:0] to_node,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [10:0] component_count,
	output logic [10:0] source_components,
	output logic [10:0] sink_components,
	output logic [10:0] max_sources_sinks,
	output logic        edge_overflow,
	output logic        node_out_of_range
);
	import scc_pkg::*;

	localparam int NW  = $clog2(MAX_NODES);
	localparam int NCW = $clog2(MAX_NODES + 1);
	localparam int ECW = $clog2(MAX_EDGES + 1);
	localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

	state_t state_q, state_d;

	logic [10:0]    num_nodes_q;
	logic [ECW-1:0] ecount_q;
	logic           err_ovf_q, err_rng_q;
	logic [NCW-1:0] n_act;

	logic [ECW-1:0] eidx_q;
	logic [NCW-1:0] nidx_q, fcount_q, depth_q, comps_q, src_q, snk_q;
	logic [NCW-1:0] kp_q [2];
	logic [NW-1:0]  k_q [2], val_q [2];
	logic [ECW-1:0] acc_q [2];
	logic           dir_q;
	logic [NW-1:0]  u_q, v_q, s_q;
	logic [ECW-1:0] p_q, end_q;

	// Edge store.
	logic [NW-1:0] ef_mem [MAX_EDGES];
	logic [NW-1:0] et_mem [MAX_EDGES];
	logic          e_we;
	logic [EW-1:0] e_wa, e_ra;
	logic [NW-1:0] e_wdf, e_wdt, ef_rd, et_rd;

	// Per-direction offset, fill and adjacency RAM controls.
	logic           off_we [2];
	logic [NCW-1:0] off_wa [2], off_ra0 [2], off_ra1 [2];
	logic [ECW-1:0] off_wd [2], off_rd0 [2], off_rd1 [2];
	logic           fill_we [2];
	logic [NW-1:0]  fill_wa [2], fill_ra [2];
	logic [ECW-1:0] fill_wd [2], fill_rd [2];
	logic           adj_we [2];
	logic [EW-1:0]  adj_wa [2], adj_ra [2];
	logic [NW-1:0]  adj_wd [2], adj_rd [2];

	// Node arrays.
	logic             vis_mem [MAX_NODES];
	logic             vis_we, vis_wd, vis_rd;
	logic [NW-1:0]    vis_wa, vis_ra;
	logic [NW-1:0]    fin_mem [MAX_NODES];
	logic             fin_we;
	logic [NW-1:0]    fin_wa, fin_ra, fin_wd, fin_rd;
	logic [NW+ECW-1:0] stk_mem [MAX_NODES];
	logic             stk_we;
	logic [NW-1:0]    stk_wa, stk_ra;
	logic [NW+ECW-1:0] stk_wd, stk_rd;
	logic [NW-1:0]    lab_mem [MAX_NODES];
	logic             lab_we;
	logic [NW-1:0]    lab_wa, lab_ra0, lab_ra1, lab_wd, lab_rd0, lab_rd1;
	logic             inx_mem [MAX_NODES];
	logic             outx_mem [MAX_NODES];
	logic             inx_we, outx_we, x_wd, inx_rd, outx_rd;
	logic [NW-1:0]    inx_wa, outx_wa, x_ra;

	logic item_fire, load_rng_bad, load_full, edge_ok, done_fire;
	logic [NW-1:0] key [2], val [2];

	always_comb begin
		if (num_nodes_q == 11'd0) begin
			n_act = NCW'(1);
		end else if (32'(num_nodes_q) > 32'(MAX_NODES)) begin
			n_act = NCW'(MAX_NODES);
		end else begin
			n_act = NCW'(num_nodes_q);
		end
	end

	assign pready       = 1'b1;
	assign prdata       = (paddr[2] == REG_NUM_NODES) ? {21'd0, num_nodes_q} : 32'd0;
	assign item_stall   = (state_q != S_IDLE);
	assign item_fire    = item_valid && !item_stall;
	assign load_rng_bad = (from_node == 11'd0) || (32'(from_node) > 32'(n_act)) ||
		(to_node == 11'd0) || (32'(to_node) > 32'(n_act));
	assign load_full    = (32'(ecount_q) >= 32'(MAX_EDGES));
	assign edge_ok      = (32'(ef_rd) < 32'(n_act)) && (32'(et_rd) < 32'(n_act));
	assign done_fire    = (state_q == S_DONE) && (!result_valid || !result_stall);
	assign key[0] = ef_rd;
	assign val[0] = et_rd;
	assign key[1] = et_rd;
	assign val[1] = ef_rd;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (item_fire && mode == MODE_RUN) state_d = S_CLR;
			S_CLR:     if (nidx_q == n_act) state_d = S_CNT_RD;
			S_CNT_RD:  state_d = (eidx_q == ecount_q) ? S_PRE_RD : S_CNT_E;
			S_CNT_E:   state_d = edge_ok ? S_CNT_O : S_CNT_RD;
			S_CNT_O:   state_d = S_CNT_RD;
			S_PRE_RD:  state_d = S_PRE_WR;
			S_PRE_WR:  state_d = (nidx_q == n_act) ? S_FILL_RD : S_PRE_RD;
			S_FILL_RD: state_d = (eidx_q == ecount_q) ? S_D1_RD : S_FILL_E;
			S_FILL_E:  state_d = edge_ok ? S_FILL_W : S_FILL_RD;
			S_FILL_W:  state_d = S_FILL_RD;
			S_D1_RD:   state_d = (nidx_q == n_act) ? S_CLRV : S_D1_CHK;
			S_D1_CHK:  state_d = vis_rd ? S_D1_RD : S_W_OFF;
			S_CLRV:    if (nidx_q == n_act) state_d = S_D2_RD;
			S_D2_RD:   state_d = (nidx_q == '0) ? S_X_RD : S_D2_FIN;
			S_D2_FIN:  state_d = S_D2_CHK;
			S_D2_CHK:  state_d = vis_rd ? S_D2_RD : S_W_OFF;
			S_W_OFF:   state_d = S_W_TOP;
			S_W_TOP: begin
				if (p_q < end_q) begin
					state_d = S_W_ADJ;
				end else if (depth_q == NCW'(1)) begin
					state_d = dir_q ? S_D2_RD : S_D1_RD;
				end else begin
					state_d = S_W_POP;
				end
			end
			S_W_ADJ:   state_d = S_W_VIS;
			S_W_VIS:   state_d = vis_rd ? S_W_TOP : S_W_OFF;
			S_W_POP:   state_d = S_W_END;
			S_W_END:   state_d = S_W_TOP;
			S_X_RD:    state_d = (eidx_q == ecount_q) ? S_SC_RD : S_X_E;
			S_X_E:     state_d = edge_ok ? S_X_L : S_X_RD;
			S_X_L:     state_d = S_X_RD;
			S_SC_RD:   state_d = (nidx_q == comps_q) ? S_DONE : S_SC_ACC;
			S_SC_ACC:  state_d = S_SC_RD;
			S_DONE:    if (done_fire) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		e_we   = 1'b0;
		e_wa   = EW'(ecount_q);
		e_wdf  = NW'(11'(from_node - 11'd1));
		e_wdt  = NW'(11'(to_node - 11'd1));
		e_ra   = EW'(eidx_q);
		for (int d = 0; d < 2; d++) begin
			off_we[d]  = 1'b0;
			off_wa[d]  = nidx_q;
			off_wd[d]  = '0;
			off_ra0[d] = nidx_q;
			off_ra1[d] = nidx_q;
			fill_we[d] = 1'b0;
			fill_wa[d] = NW'(nidx_q);
			fill_wd[d] = '0;
			fill_ra[d] = key[d];
			adj_we[d]  = 1'b0;
			adj_wa[d]  = EW'(fill_rd[d]);
			adj_wd[d]  = val_q[d];
			adj_ra[d]  = EW'(p_q);
		end
		vis_we  = 1'b0;
		vis_wa  = NW'(nidx_q);
		vis_wd  = 1'b0;
		vis_ra  = NW'(nidx_q);
		fin_we  = 1'b0;
		fin_wa  = NW'(fcount_q);
		fin_wd  = u_q;
		fin_ra  = NW'(nidx_q - NCW'(1));
		stk_we  = 1'b0;
		stk_wa  = NW'(depth_q - NCW'(1));
		stk_wd  = {u_q, p_q};
		stk_ra  = NW'(depth_q - NCW'(2));
		lab_we  = 1'b0;
		lab_wa  = u_q;
		lab_wd  = NW'(comps_q);
		lab_ra0 = ef_rd;
		lab_ra1 = et_rd;
		inx_we  = 1'b0;
		outx_we = 1'b0;
		inx_wa  = NW'(nidx_q);
		outx_wa = NW'(nidx_q);
		x_wd    = 1'b0;
		x_ra    = NW'(nidx_q);
		case (state_q)
			S_IDLE: begin
				e_we = item_fire && (mode == MODE_EDGE) && !load_rng_bad && !load_full;
			end
			S_CLR: begin
				for (int d = 0; d < 2; d++) begin
					off_we[d] = 1'b1;
				end
				vis_we  = (nidx_q < n_act);
				inx_we  = (nidx_q < n_act);
				outx_we = (nidx_q < n_act);
			end
			S_CNT_E: begin
				for (int d = 0; d < 2; d++) begin
					off_ra0[d] = NCW'(key[d]) + NCW'(1);
				end
			end
			S_CNT_O: begin
				for (int d = 0; d < 2; d++) begin
					off_we[d] = 1'b1;
					off_wa[d] = kp_q[d];
					off_wd[d] = off_rd0[d] + ECW'(1);
				end
			end
			S_PRE_WR: begin
				for (int d = 0; d < 2; d++) begin
					off_we[d]  = 1'b1;
					off_wd[d]  = acc_q[d] + off_rd0[d];
					fill_we[d] = (nidx_q < n_act);
					fill_wd[d] = acc_q[d] + off_rd0[d];
				end
			end
			S_FILL_W: begin
				for (int d = 0; d < 2; d++) begin
					adj_we[d]  = 1'b1;
					fill_we[d] = 1'b1;
					fill_wa[d] = k_q[d];
					fill_wd[d] = fill_rd[d] + ECW'(1);
				end
			end
			S_D1_CHK, S_D2_CHK: begin
				vis_wa = (state_q == S_D1_CHK) ? NW'(nidx_q) : s_q;
				vis_we = !vis_rd;
				vis_wd = 1'b1;
				for (int d = 0; d < 2; d++) begin
					off_ra0[d] = NCW'(vis_wa);
					off_ra1[d] = NCW'(vis_wa) + NCW'(1);
				end
			end
			S_CLRV: begin
				vis_we = (nidx_q < n_act);
			end
			S_D2_FIN: begin
				vis_ra = fin_rd;
			end
			S_W_TOP: begin
				if (!(p_q < end_q)) begin
					fin_we = !dir_q;
					lab_we = dir_q;
				end
			end
			S_W_ADJ: begin
				vis_ra = adj_rd[dir_q];
			end
			S_W_VIS: begin
				if (!vis_rd) begin
					vis_we = 1'b1;
					vis_wa = v_q;
					vis_wd = 1'b1;
					stk_we = 1'b1;
					for (int d = 0; d < 2; d++) begin
						off_ra0[d] = NCW'(v_q);
						off_ra1[d] = NCW'(v_q) + NCW'(1);
					end
				end
			end
			S_W_POP: begin
				for (int d = 0; d < 2; d++) begin
					off_ra1[d] = NCW'(stk_rd[NW+ECW-1:ECW]) + NCW'(1);
				end
			end
			S_X_L: begin
				x_wd    = 1'b1;
				outx_we = (lab_rd0 != lab_rd1);
				inx_we  = (lab_rd0 != lab_rd1);
				outx_wa = lab_rd0;
				inx_wa  = lab_rd1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (e_we) begin
			ef_mem[e_wa] <= e_wdf;
			et_mem[e_wa] <= e_wdt;
		end
		ef_rd <= ef_mem[e_ra];
		et_rd <= et_mem[e_ra];
	end

	for (genvar d = 0; d < 2; d++) begin : g_dir
		logic [ECW-1:0] off_mem [MAX_NODES+1];
		logic [ECW-1:0] fill_mem [MAX_NODES];
		logic [NW-1:0]  adj_mem [MAX_EDGES];

		always_ff @(posedge clk) begin
			if (off_we[d]) off_mem[off_wa[d]] <= off_wd[d];
			off_rd0[d] <= off_mem[off_ra0[d]];
			off_rd1[d] <= off_mem[off_ra1[d]];
		end

		always_ff @(posedge clk) begin
			if (fill_we[d]) fill_mem[fill_wa[d]] <= fill_wd[d];
			fill_rd[d] <= fill_mem[fill_ra[d]];
		end

		always_ff @(posedge clk) begin
			if (adj_we[d]) adj_mem[adj_wa[d]] <= adj_wd[d];
			adj_rd[d] <= adj_mem[adj_ra[d]];
		end
	end

	always_ff @(posedge clk) begin
		if (vis_we) vis_mem[vis_wa] <= vis_wd;
		vis_rd <= vis_mem[vis_ra];
	end

	always_ff @(posedge clk) begin
		if (fin_we) fin_mem[fin_wa] <= fin_wd;
		fin_rd <= fin_mem[fin_ra];
	end

	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[stk_wa] <= stk_wd;
		stk_rd <= stk_mem[stk_ra];
	end

	always_ff @(posedge clk) begin
		if (lab_we) lab_mem[lab_wa] <= lab_wd;
		lab_rd0 <= lab_mem[lab_ra0];
		lab_rd1 <= lab_mem[lab_ra1];
	end

	always_ff @(posedge clk) begin
		if (inx_we) inx_mem[inx_wa] <= x_wd;
		if (outx_we) outx_mem[outx_wa] <= x_wd;
		inx_rd  <= inx_mem[x_ra];
		outx_rd <= outx_mem[x_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			num_nodes_q  <= 11'd1;
			ecount_q     <= '0;
			err_ovf_q    <= 1'b0;
			err_rng_q    <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite && paddr[2] == REG_NUM_NODES) begin
				num_nodes_q <= pwdata[10:0];
			end
			if (state_q == S_IDLE && item_fire && mode == MODE_EDGE) begin
				if (load_rng_bad) begin
					err_rng_q <= 1'b1;
				end else if (load_full) begin
					err_ovf_q <= 1'b1;
				end else begin
					ecount_q <= ecount_q + ECW'(1);
				end
			end
			if (result_valid && !result_stall) begin
				result_valid <= 1'b0;
			end
			if (done_fire) begin
				result_valid <= 1'b1;
				ecount_q     <= '0;
				err_ovf_q    <= 1'b0;
				err_rng_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				nidx_q <= '0;
			end
			S_CLR: begin
				nidx_q <= nidx_q + NCW'(1);
				eidx_q <= '0;
			end
			S_CNT_RD: begin
				nidx_q <= '0;
				for (int d = 0; d < 2; d++) begin
					acc_q[d] <= '0;
				end
			end
			S_CNT_E: begin
				for (int d = 0; d < 2; d++) begin
					kp_q[d] <= NCW'(key[d]) + NCW'(1);
				end
				if (!edge_ok) eidx_q <= eidx_q + ECW'(1);
			end
			S_CNT_O, S_FILL_W, S_X_L: begin
				eidx_q <= eidx_q + ECW'(1);
			end
			S_PRE_WR: begin
				for (int d = 0; d < 2; d++) begin
					acc_q[d] <= acc_q[d] + off_rd0[d];
				end
				nidx_q <= nidx_q + NCW'(1);
				eidx_q <= '0;
			end
			S_FILL_RD: begin
				nidx_q   <= '0;
				fcount_q <= '0;
				dir_q    <= 1'b0;
			end
			S_FILL_E: begin
				for (int d = 0; d < 2; d++) begin
					k_q[d]   <= key[d];
					val_q[d] <= val[d];
				end
				if (!edge_ok) eidx_q <= eidx_q + ECW'(1);
			end
			S_D1_RD: begin
				if (nidx_q == n_act) nidx_q <= '0;
			end
			S_D1_CHK: begin
				if (vis_rd) begin
					nidx_q <= nidx_q + NCW'(1);
				end else begin
					u_q     <= NW'(nidx_q);
					depth_q <= NCW'(1);
				end
			end
			S_CLRV: begin
				if (nidx_q == n_act) begin
					nidx_q  <= fcount_q;
					dir_q   <= 1'b1;
					comps_q <= '0;
				end else begin
					nidx_q <= nidx_q + NCW'(1);
				end
			end
			S_D2_RD: begin
				eidx_q <= '0;
			end
			S_D2_FIN: begin
				s_q <= fin_rd;
			end
			S_D2_CHK: begin
				if (vis_rd) begin
					nidx_q <= nidx_q - NCW'(1);
				end else begin
					u_q     <= s_q;
					depth_q <= NCW'(1);
				end
			end
			S_W_OFF: begin
				p_q   <= off_rd0[dir_q];
				end_q <= off_rd1[dir_q];
			end
			S_W_TOP: begin
				if (p_q < end_q) begin
					p_q <= p_q + ECW'(1);
				end else begin
					depth_q <= depth_q - NCW'(1);
					if (!dir_q) fcount_q <= fcount_q + NCW'(1);
					if (depth_q == NCW'(1)) begin
						if (dir_q) begin
							comps_q <= comps_q + NCW'(1);
							nidx_q  <= nidx_q - NCW'(1);
						end else begin
							nidx_q <= nidx_q + NCW'(1);
						end
					end
				end
			end
			S_W_ADJ: begin
				v_q <= adj_rd[dir_q];
			end
			S_W_VIS: begin
				if (!vis_rd) begin
					u_q     <= v_q;
					depth_q <= depth_q + NCW'(1);
				end
			end
			S_W_POP: begin
				u_q <= stk_rd[NW+ECW-1:ECW];
				p_q <= stk_rd[ECW-1:0];
			end
			S_W_END: begin
				end_q <= off_rd1[dir_q];
			end
			S_X_RD: begin
				nidx_q <= '0;
				src_q  <= '0;
				snk_q  <= '0;
			end
			S_X_E: begin
				if (!edge_ok) eidx_q <= eidx_q + ECW'(1);
			end
			S_SC_ACC: begin
				src_q  <= src_q + NCW'(!inx_rd);
				snk_q  <= snk_q + NCW'(!outx_rd);
				nidx_q <= nidx_q + NCW'(1);
			end
			S_DONE: begin
				if (done_fire) begin
					component_count   <= 11'(comps_q);
					source_components <= 11'(src_q);
					sink_components   <= 11'(snk_q);
					max_sources_sinks <= (src_q > snk_q) ? 11'(src_q) : 11'(snk_q);
					edge_overflow     <= err_ovf_q;
					node_out_of_range <= err_rng_q;
				end
			end
			default: begin
			end
		endcase
	end

	`SCC_ASSERT_NEXT(a_run_holds_input, item_fire && mode == MODE_RUN, item_stall, "no stall")
	`SCC_ASSERT_IMPL(a_edge_cap, 1'b1, 32'(ecount_q) <= 32'(MAX_EDGES), "edge count too big")
	`SCC_ASSERT_IMPL(a_depth_bound, state_q == S_W_TOP, depth_q <= n_act && depth_q != '0, "bad depth")
	`SCC_ASSERT_NEXT(a_result_once, result_valid && !result_stall && !done_fire, !result_valid, "repeat")

endmodule
